// ===== hw/rtl/afam_pkg.sv =====
// ----------------------------------------------------------------------------
// afam_pkg
// shared constants, types and the arctangent table for the attitude pipeline
// ----------------------------------------------------------------------------
package afam_pkg;

   localparam int SampleWidthDefault = 16;

   localparam int OpW         = 32;
   localparam int SqrtLat     = 32;
   localparam int NormSteps   = 6;
   localparam int CordicSteps = 27;
   localparam int AtanLat     = NormSteps + CordicSteps + 1;
   localparam int PostLat     = 5;

   localparam int CsrAddrW = 3;
   localparam logic RegDeclIdx = 1'b0;

   localparam logic signed [15:0] DeclResetVal = -16'sd345;

   localparam logic signed [31:0] Micro90     = 32'sd90000000;
   localparam logic signed [31:0] Micro180    = 32'sd180000000;
   localparam logic signed [31:0] Micro360    = 32'sd360000000;
   localparam logic signed [31:0] MicroPerCd  = 32'sd10000;
   localparam logic [28:0]        HalfCenti   = 29'd5000;

   // 2^44 / 10000 rounded up
   localparam int         RecipShift = 44;
   localparam logic [30:0] RecipK    = 31'd1759218605;

   typedef struct packed {
      logic          yneg;
      logic [OpW-1:0] ym;
      logic          xneg;
      logic [OpW-1:0] xm;
   } afam_opnd_type;

   function automatic logic [25:0] atan_micro(input logic [4:0] idx);
      logic [25:0] v;
      unique case (idx)
         5'd0:    v = 26'd45000000;
         5'd1:    v = 26'd26565051;
         5'd2:    v = 26'd14036243;
         5'd3:    v = 26'd7125016;
         5'd4:    v = 26'd3576334;
         5'd5:    v = 26'd1789911;
         5'd6:    v = 26'd895174;
         5'd7:    v = 26'd447614;
         5'd8:    v = 26'd223811;
         5'd9:    v = 26'd111906;
         5'd10:   v = 26'd55953;
         5'd11:   v = 26'd27976;
         5'd12:   v = 26'd13988;
         5'd13:   v = 26'd6994;
         5'd14:   v = 26'd3497;
         5'd15:   v = 26'd1749;
         5'd16:   v = 26'd874;
         5'd17:   v = 26'd437;
         5'd18:   v = 26'd219;
         5'd19:   v = 26'd109;
         5'd20:   v = 26'd55;
         5'd21:   v = 26'd27;
         5'd22:   v = 26'd14;
         5'd23:   v = 26'd7;
         5'd24:   v = 26'd3;
         5'd25:   v = 26'd2;
         5'd26:   v = 26'd1;
         default: v = 26'd0;
      endcase
      return v;
   endfunction

endpackage

// ===== hw/rtl/attitude_from_accel_mag.sv =====
// ----------------------------------------------------------------------------
// attitude_from_accel_mag
// roll, pitch and declination-corrected heading from accel and mag samples
// ----------------------------------------------------------------------------
// Takes one request per clock while the result side does not stall and
// returns roll, pitch and heading in hundredths of a degree: squaring and
// sum, square root (one root bit per stage), atan2 (6 normalize stages, 27
// cordic stages, 1 quadrant stage, three units in parallel), then declination,
// wrap and rounding. A stall on the result side freezes the whole pipeline;
// nothing is dropped or repeated.
// The declination register sits at csr address 0 and resets to -3.45 deg.
// ----------------------------------------------------------------------------
module attitude_from_accel_mag import afam_pkg::*; #(
   parameter int SAMPLE_WIDTH = SampleWidthDefault
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic [SAMPLE_WIDTH-1:0]    req_accel_x,
   input  logic [SAMPLE_WIDTH-1:0]    req_accel_y,
   input  logic [SAMPLE_WIDTH-1:0]    req_accel_z,
   input  logic [SAMPLE_WIDTH-1:0]    req_mag_x,
   input  logic [SAMPLE_WIDTH-1:0]    req_mag_y,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic signed [15:0]         rsp_roll_centideg,
   output logic signed [14:0]         rsp_pitch_centideg,
   output logic signed [15:0]         rsp_heading_centideg,
   input  logic                       csr_psel,
   input  logic                       csr_penable,
   input  logic                       csr_pwrite,
   input  logic [CsrAddrW-1:0]        csr_paddr,
   input  logic [31:0]                csr_pwdata,
   output logic [31:0]                csr_prdata,
   output logic                       csr_pready
);

   localparam int Frac = 32 - SAMPLE_WIDTH;
   localparam int Lat  = 3 + SqrtLat + AtanLat + PostLat;

   typedef struct packed {
      afam_opnd_type  roll;
      afam_opnd_type  head;
      logic           pyneg;
      logic [OpW-1:0] pym;
   } afam_side_type;

   logic                 adv;
   logic [Lat:1]         vld_ff;
   logic signed [15:0]   dec_ff;

   logic [SAMPLE_WIDTH-1:0] ax1_ff, ay1_ff, az1_ff, mx1_ff, my1_ff;
   logic [SAMPLE_WIDTH-1:0] max_m, may_m, maz_m, mmx_m, mmy_m;
   logic [2*SAMPLE_WIDTH-1:0] sqy2_ff, sqz2_ff;
   afam_side_type        side2_ff, side2_in;
   afam_side_type        side3_ff;
   logic [63:0]          rad3_ff;
   afam_side_type        dly_ff [SqrtLat];
   logic [31:0]          root;
   afam_opnd_type        pitch_op;
   logic signed [31:0]   a_roll, a_pitch, a_head;

   logic signed [31:0]   ang1_ff [3];
   logic signed [31:0]   ang2_ff [3];
   logic signed [31:0]   ang2_in [3];
   logic [28:0]          mag3_ff [3];
   logic [28:0]          mag3_in [3];
   logic [2:0]           neg3_ff, neg4_ff;
   logic [59:0]          prod4_ff [3];
   logic [15:0]          q5 [3];
   logic signed [15:0]   out5_in [3];
   logic signed [15:0]   roll_ff, head_ff;
   logic signed [14:0]   pitch_ff;
   logic [31:0]          abs_v [3];

   function automatic logic [SAMPLE_WIDTH-1:0] mag_of(input logic [SAMPLE_WIDTH-1:0] v);
      return v[SAMPLE_WIDTH-1] ? (~v + 1'b1) : v;
   endfunction

   assign adv       = !(vld_ff[Lat] && rsp_stall);
   assign req_stall = !adv;
   assign rsp_valid = vld_ff[Lat];

   // configuration port
   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[2] == RegDeclIdx) ? 32'(dec_ff) : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         dec_ff <= DeclResetVal;
      end else if (csr_psel && csr_penable && csr_pwrite && csr_paddr[2] == RegDeclIdx) begin
         dec_ff <= $signed(csr_pwdata[15:0]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= {vld_ff[Lat-1:1], req_valid};
      end
   end

   // front end: magnitudes, squares, radicand
   always_comb begin
      max_m = mag_of(ax1_ff);
      may_m = mag_of(ay1_ff);
      maz_m = mag_of(az1_ff);
      mmx_m = mag_of(mx1_ff);
      mmy_m = mag_of(my1_ff);
      side2_in.roll.yneg = ay1_ff[SAMPLE_WIDTH-1];
      side2_in.roll.ym   = OpW'(may_m);
      side2_in.roll.xneg = az1_ff[SAMPLE_WIDTH-1];
      side2_in.roll.xm   = OpW'(maz_m);
      side2_in.head.yneg = mx1_ff[SAMPLE_WIDTH-1];
      side2_in.head.xm   = OpW'(mmy_m);
      if (my1_ff == '0) begin
         side2_in.head.ym   = '0;
         side2_in.head.xneg = mx1_ff[SAMPLE_WIDTH-1];
      end else begin
         side2_in.head.ym   = OpW'(mmx_m);
         side2_in.head.xneg = my1_ff[SAMPLE_WIDTH-1];
      end
      side2_in.pyneg = !ax1_ff[SAMPLE_WIDTH-1] && (ax1_ff != '0);
      side2_in.pym   = OpW'(max_m) << Frac;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         ax1_ff   <= req_accel_x;
         ay1_ff   <= req_accel_y;
         az1_ff   <= req_accel_z;
         mx1_ff   <= req_mag_x;
         my1_ff   <= req_mag_y;
         sqy2_ff  <= may_m * may_m;
         sqz2_ff  <= maz_m * maz_m;
         side2_ff <= side2_in;
         rad3_ff  <= 64'({1'b0, sqy2_ff} + {1'b0, sqz2_ff}) << (2 * Frac);
         side3_ff <= side2_ff;
         dly_ff[0] <= side3_ff;
         for (int k = 1; k < SqrtLat; k++) begin
            dly_ff[k] <= dly_ff[k-1];
         end
      end
   end

   afam_isqrt u_isqrt (
      .clock    (clock),
      .en       (adv),
      .radicand (rad3_ff),
      .root     (root)
   );

   assign pitch_op = '{yneg: dly_ff[SqrtLat-1].pyneg, ym: dly_ff[SqrtLat-1].pym,
                       xneg: 1'b0, xm: root};

   afam_atan2 u_atan_roll (
      .clock (clock), .en (adv), .op (dly_ff[SqrtLat-1].roll), .angle (a_roll)
   );

   afam_atan2 u_atan_pitch (
      .clock (clock), .en (adv), .op (pitch_op), .angle (a_pitch)
   );

   afam_atan2 u_atan_head (
      .clock (clock), .en (adv), .op (dly_ff[SqrtLat-1].head), .angle (a_head)
   );

   // back end: declination, wrap, rounding to centidegrees
   always_comb begin
      ang2_in[0] = ang1_ff[0];
      ang2_in[1] = ang1_ff[1];
      if (ang1_ff[2] > Micro180) begin
         ang2_in[2] = ang1_ff[2] - Micro360;
      end else if (ang1_ff[2] < -Micro180) begin
         ang2_in[2] = ang1_ff[2] + Micro360;
      end else begin
         ang2_in[2] = ang1_ff[2];
      end
      for (int k = 0; k < 3; k++) begin
         abs_v[k]   = ang2_ff[k][31] ? 32'(-ang2_ff[k]) : 32'(ang2_ff[k]);
         mag3_in[k] = 29'(abs_v[k]) + HalfCenti;
         q5[k]      = prod4_ff[k][RecipShift +: 16];
         out5_in[k] = neg4_ff[k] ? -$signed(q5[k]) : $signed(q5[k]);
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         ang1_ff[0] <= a_roll;
         ang1_ff[1] <= a_pitch;
         ang1_ff[2] <= a_head - 32'(dec_ff * MicroPerCd);
         for (int k = 0; k < 3; k++) begin
            ang2_ff[k]  <= ang2_in[k];
            mag3_ff[k]  <= mag3_in[k];
            neg3_ff[k]  <= ang2_ff[k][31];
            prod4_ff[k] <= mag3_ff[k] * RecipK;
            neg4_ff[k]  <= neg3_ff[k];
         end
         roll_ff  <= out5_in[0];
         pitch_ff <= out5_in[1][14:0];
         head_ff  <= out5_in[2];
      end
   end

   assign rsp_roll_centideg    = roll_ff;
   assign rsp_pitch_centideg   = pitch_ff;
   assign rsp_heading_centideg = head_ff;

`ifndef SYNTHESIS
   a_stall_freezes: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |-> req_stall)
      else $error("input taken while result stalled");

   a_pitch_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_pitch_centideg >= -15'sd9000 && rsp_pitch_centideg <= 15'sd9000))
      else $error("pitch out of range");

   a_roll_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_roll_centideg >= -16'sd18000 && rsp_roll_centideg <= 16'sd18000))
      else $error("roll out of range");

   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result valid right after reset");
`endif

endmodule

// ===== hw/rtl/afam_isqrt.sv =====
// ----------------------------------------------------------------------------
// afam_isqrt
// pipelined floor square root of a 64 bit radicand, one root bit per stage
// ----------------------------------------------------------------------------
module afam_isqrt import afam_pkg::*; (
   input  logic        clock,
   input  logic        en,
   input  logic [63:0] radicand,
   output logic [31:0] root
);

   typedef struct packed {
      logic [33:0] rem;
      logic [31:0] root;
      logic [63:0] rad;
   } afam_sq_type;

   function automatic afam_sq_type sq_step(input afam_sq_type s);
      afam_sq_type n;
      logic [35:0] rt;
      logic [35:0] t;
      rt = {s.rem, s.rad[63:62]};
      t  = {2'b00, s.root, 2'b01};
      if (rt >= t) begin
         n.rem  = 34'(rt - t);
         n.root = {s.root[30:0], 1'b1};
      end else begin
         n.rem  = 34'(rt);
         n.root = {s.root[30:0], 1'b0};
      end
      n.rad = {s.rad[61:0], 2'b00};
      return n;
   endfunction

   afam_sq_type st_ff [SqrtLat];
   afam_sq_type st_in [SqrtLat];

   always_comb begin
      st_in[0] = sq_step('{rem: '0, root: '0, rad: radicand});
      for (int k = 1; k < SqrtLat; k++) begin
         st_in[k] = sq_step(st_ff[k-1]);
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 0; k < SqrtLat; k++) begin
            st_ff[k] <= st_in[k];
         end
      end
   end

   assign root = st_ff[SqrtLat-1].root;

endmodule

// ===== hw/rtl/afam_atan2.sv =====
// ----------------------------------------------------------------------------
// afam_atan2
// pipelined atan2 in microdegrees: staged normalize, cordic vectoring, quadrant
// ----------------------------------------------------------------------------
module afam_atan2 import afam_pkg::*; (
   input  logic                clock,
   input  logic                en,
   input  afam_opnd_type       op,
   output logic signed [31:0]  angle
);

   typedef struct packed {
      logic yneg;
      logic xneg;
      logic yz;
      logic xz;
   } afam_flag_type;

   typedef struct packed {
      logic [60:0]   x;
      logic [60:0]   y;
      afam_flag_type f;
   } afam_norm_type;

   typedef struct packed {
      logic signed [63:0] x;
      logic signed [63:0] y;
      logic signed [31:0] a;
      afam_flag_type      f;
   } afam_rot_type;

   function automatic afam_norm_type norm_step(input afam_norm_type s, input int sh);
      afam_norm_type n;
      logic [60:0] orv;
      n   = s;
      orv = s.x | s.y;
      if ((orv >> (61 - sh)) == '0) begin
         n.x = s.x << sh;
         n.y = s.y << sh;
      end
      return n;
   endfunction

   function automatic afam_rot_type rot_step(input afam_rot_type c, input int i);
      afam_rot_type n;
      logic signed [63:0] xs;
      logic signed [63:0] ys;
      logic signed [31:0] t;
      n  = c;
      xs = c.x >>> i;
      ys = c.y >>> i;
      t  = $signed(32'(atan_micro(5'(i))));
      if (c.y > 0) begin
         n.x = c.x + ys;
         n.y = c.y - xs;
         n.a = c.a + t;
      end else begin
         n.x = c.x - ys;
         n.y = c.y + xs;
         n.a = c.a - t;
      end
      return n;
   endfunction

   afam_norm_type     nm_ff [NormSteps];
   afam_norm_type     nm_in [NormSteps];
   afam_rot_type      rt_ff [CordicSteps];
   afam_rot_type      rt_in [CordicSteps];
   logic signed [31:0] angle_ff;
   logic signed [31:0] angle_in;
   afam_norm_type     nm_src;
   afam_rot_type      rt_src;
   afam_rot_type      last;
   logic signed [31:0] clamped;
   logic signed [31:0] folded;

   always_comb begin
      nm_src.x      = 61'(op.xm);
      nm_src.y      = 61'(op.ym);
      nm_src.f.yneg = op.yneg;
      nm_src.f.xneg = op.xneg;
      nm_src.f.yz   = (op.ym == '0);
      nm_src.f.xz   = (op.xm == '0);
      nm_in[0] = norm_step(nm_src, 32);
      for (int k = 1; k < NormSteps; k++) begin
         nm_in[k] = norm_step(nm_ff[k-1], 32 >> k);
      end

      rt_src.x = $signed({3'b000, nm_ff[NormSteps-1].x});
      rt_src.y = $signed({3'b000, nm_ff[NormSteps-1].y});
      rt_src.a = '0;
      rt_src.f = nm_ff[NormSteps-1].f;
      rt_in[0] = rot_step(rt_src, 0);
      for (int i = 1; i < CordicSteps; i++) begin
         rt_in[i] = rot_step(rt_ff[i-1], i);
      end

      last = rt_ff[CordicSteps-1];
      if (last.a < 0) begin
         clamped = '0;
      end else if (last.a > Micro90) begin
         clamped = Micro90;
      end else begin
         clamped = last.a;
      end
      if (last.f.xz) begin
         clamped = Micro90;
      end
      folded = last.f.xneg ? (Micro180 - clamped) : clamped;
      if (last.f.yz) begin
         angle_in = last.f.xneg ? Micro180 : '0;
      end else begin
         angle_in = last.f.yneg ? -folded : folded;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 0; k < NormSteps; k++) begin
            nm_ff[k] <= nm_in[k];
         end
         for (int i = 0; i < CordicSteps; i++) begin
            rt_ff[i] <= rt_in[i];
         end
         angle_ff <= angle_in;
      end
   end

   assign angle = angle_ff;

endmodule

// ===== sim/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the attitude pipeline
// ----------------------------------------------------------------------------
// Sends accel and mag sample sets with random gaps and random result stalls.
// A bit-exact fixed-point model in the scoreboard predicts roll, pitch and
// heading for each accepted request. Actual results are compared in order.
// The declination register keeps its reset value in the first phase, then is
// rewritten: both range extremes, values outside the range, zero and random.
// One long result stall fills the pipeline, so the input side stalls too.
// ----------------------------------------------------------------------------
module tb_top import afam_pkg::*; ;

   localparam longint M90  = 64'sd90000000;
   localparam longint M180 = 64'sd180000000;
   localparam longint M360 = 64'sd360000000;
   localparam longint StepAngle [27] = '{
      45000000, 26565051, 14036243, 7125016, 3576334, 1789911, 895174,
      447614, 223811, 111906, 55953, 27976, 13988, 6994, 3497, 1749,
      874, 437, 219, 109, 55, 27, 14, 7, 3, 2, 1};
   localparam logic [CsrAddrW-1:0] DeclAddr = {RegDeclIdx, 2'b00};
   localparam int WatchLimit = 20000;
   localparam int LongHold   = 3000;

   typedef struct {
      logic [15:0] roll;
      logic [14:0] pitch;
      logic [15:0] heading;
   } attitude_type;

   class attitude_board;
      attitude_type pending[$];
      longint      decl_cd;
      int          errors;
      int          matched;

      function new();
         decl_cd = -345;
         errors  = 0;
         matched = 0;
      endfunction

      function longint atan2_micro(bit yneg, bit [63:0] ym, bit xneg, bit [63:0] xm);
         longint a, x, y, xs, ys;
         bit [63:0] big;
         int l;
         if (ym == 0) return xneg ? M180 : 0;
         if (xm == 0) begin
            a = M90;
         end else begin
            big = (xm > ym) ? xm : ym;
            l = 0;
            while (big != 0) begin
               l++;
               big >>= 1;
            end
            if (l > 61) begin
               xm >>= (l - 61);
               ym >>= (l - 61);
            end else begin
               xm <<= (61 - l);
               ym <<= (61 - l);
            end
            x = $signed(xm);
            y = $signed(ym);
            a = 0;
            for (int i = 0; i < 27; i++) begin
               xs = x >>> i;
               ys = y >>> i;
               if (y > 0) begin
                  x = x + ys;
                  y = y - xs;
                  a += StepAngle[i];
               end else begin
                  x = x - ys;
                  y = y + xs;
                  a -= StepAngle[i];
               end
            end
            if (a < 0) a = 0;
            if (a > M90) a = M90;
         end
         if (xneg) a = M180 - a;
         return yneg ? -a : a;
      endfunction

      function bit [63:0] root(bit [63:0] s);
         bit [63:0] r, b;
         r = 0;
         b = 64'd1 << 62;
         while (b > s) b >>= 2;
         while (b != 0) begin
            if (s >= r + b) begin
               s -= r + b;
               r = (r >> 1) + b;
            end else begin
               r >>= 1;
            end
            b >>= 2;
         end
         return r;
      endfunction

      function longint to_centi(longint v);
         bit [63:0] m;
         longint q;
         m = (v < 0) ? -v : v;
         q = (m + 5000) / 10000;
         return (v < 0) ? -q : q;
      endfunction

      function bit [63:0] mag(longint v);
         return (v < 0) ? -v : v;
      endfunction

      function void note(logic [15:0] ax, logic [15:0] ay, logic [15:0] az,
                         logic [15:0] mx, logic [15:0] my);
         longint sax, say, saz, smx, smy, r_ang, p_ang, h_ang;
         bit [63:0] rad;
         longint rc, pc, hc;
         attitude_type e;
         sax = $signed(ax);
         say = $signed(ay);
         saz = $signed(az);
         smx = $signed(mx);
         smy = $signed(my);
         rad = root((mag(say) * mag(say) + mag(saz) * mag(saz)) << 32);
         r_ang = atan2_micro(say < 0, mag(say), saz < 0, mag(saz));
         p_ang = atan2_micro(sax > 0, mag(sax) << 16, 1'b0, rad);
         if (smy == 0) h_ang = (smx < 0) ? M180 : 0;
         else h_ang = atan2_micro(smx < 0, mag(smx), smy < 0, mag(smy));
         h_ang -= decl_cd * 10000;
         if (h_ang > M180) h_ang -= M360;
         else if (h_ang < -M180) h_ang += M360;
         rc = to_centi(r_ang);
         pc = to_centi(p_ang);
         hc = to_centi(h_ang);
         e.roll    = rc[15:0];
         e.pitch   = pc[14:0];
         e.heading = hc[15:0];
         pending.push_back(e);
      endfunction

      function void check(logic [15:0] roll, logic [14:0] pitch, logic [15:0] heading);
         attitude_type e;
         if (pending.size() == 0) begin
            $display("%0t: unexpected result roll=%0d pitch=%0d heading=%0d", $time,
                     $signed(roll), $signed(pitch), $signed(heading));
            errors++;
            return;
         end
         e = pending.pop_front();
         if (roll !== e.roll) begin
            $display("%0t: roll expected %0d actual %0d", $time, $signed(e.roll),
                     $signed(roll));
            errors++;
         end
         if (pitch !== e.pitch) begin
            $display("%0t: pitch expected %0d actual %0d", $time, $signed(e.pitch),
                     $signed(pitch));
            errors++;
         end
         if (heading !== e.heading) begin
            $display("%0t: heading expected %0d actual %0d", $time, $signed(e.heading),
                     $signed(heading));
            errors++;
         end
         matched++;
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [15:0] req_accel_x = '0, req_accel_y = '0, req_accel_z = '0;
   logic [15:0] req_mag_x = '0, req_mag_y = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic signed [15:0] rsp_roll_centideg;
   logic signed [14:0] rsp_pitch_centideg;
   logic signed [15:0] rsp_heading_centideg;
   logic        csr_psel = 1'b0, csr_penable = 1'b0, csr_pwrite = 1'b0;
   logic [CsrAddrW-1:0] csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   attitude_board board = new();
   int  idle_cycles = 0;
   int  requests_sent = 0;
   bit  hold_ask = 1'b0;
   bit  calm = 1'b0;

   always #5 clock = ~clock;

   attitude_from_accel_mag u_top (.*);

   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) begin
            board.note(req_accel_x, req_accel_y, req_accel_z, req_mag_x, req_mag_y);
            requests_sent++;
         end
         if (rsp_valid && !rsp_stall)
            board.check(rsp_roll_centideg, rsp_pitch_centideg, rsp_heading_centideg);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || csr_psel)
            idle_cycles = 0;
         else
            idle_cycles++;
         if (idle_cycles >= WatchLimit) begin
            $display("%0t: watchdog expired", $time);
            $display("FAILED: results differ");
            $finish;
         end
      end
   end

   function automatic int gap_len();
      int p;
      p = $urandom_range(0, 99);
      if (calm || p < 60) return 0;
      if (p < 95) return $urandom_range(1, 3);
      return $urandom_range(10, 60);
   endfunction

   // result-side stall pattern
   initial begin
      forever begin
         @(negedge clock);
         if (hold_ask) begin
            rsp_stall = 1'b1;
            repeat (LongHold) @(negedge clock);
            hold_ask = 1'b0;
            rsp_stall = 1'b0;
         end else begin
            rsp_stall = (gap_len() != 0);
         end
      end
   end

   task automatic send(logic [15:0] ax, logic [15:0] ay, logic [15:0] az,
                       logic [15:0] mx, logic [15:0] my);
      int g;
      @(negedge clock);
      req_accel_x = ax;
      req_accel_y = ay;
      req_accel_z = az;
      req_mag_x   = mx;
      req_mag_y   = my;
      req_valid   = 1'b1;
      do @(posedge clock); while (req_stall);
      g = gap_len();
      if (g > 0) begin
         @(negedge clock);
         req_valid = 1'b0;
         repeat (g - 1) @(negedge clock);
      end
   endtask

   function automatic logic [15:0] rand_sample();
      int p;
      p = $urandom_range(0, 99);
      if (p < 60) return 16'($urandom());
      if (p < 80) return 16'($signed($urandom_range(0, 128)) - 64);
      if (p < 90) return 16'h0000;
      if (p < 95) return 16'h8000;
      return 16'h7fff;
   endfunction

   task automatic drain();
      @(negedge clock);
      req_valid = 1'b0;
      while (board.pending.size() != 0) @(negedge clock);
      repeat (100) @(negedge clock);
   endtask

   task automatic write_decl(logic signed [15:0] v);
      @(negedge clock);
      csr_psel   = 1'b1;
      csr_pwrite = 1'b1;
      csr_paddr  = DeclAddr;
      csr_pwdata = {{16{v[15]}}, v};
      @(negedge clock);
      csr_penable = 1'b1;
      do @(posedge clock); while (!csr_pready);
      @(negedge clock);
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
      board.decl_cd = v;
   endtask

   task automatic random_phase(int n);
      repeat (n) send(rand_sample(), rand_sample(), rand_sample(), rand_sample(),
                      rand_sample());
   endtask

   initial begin
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // extremes, zero operands and exact-axis cases at reset declination
      send(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
      send(16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff);
      send(16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000);
      send(16'h8000, 16'h7fff, 16'h8000, 16'h7fff, 16'h8000);
      send(16'h7fff, 16'h8000, 16'h7fff, 16'h8000, 16'h7fff);
      send(16'h0000, 16'h0000, 16'h8000, 16'h8000, 16'h0000);
      send(16'h0000, 16'h0000, 16'h0001, 16'h0001, 16'h0000);
      send(16'h0001, 16'h0001, 16'h0000, 16'h0000, 16'h0001);
      send(16'hffff, 16'hffff, 16'h0000, 16'h0000, 16'hffff);
      send(16'h0001, 16'h0000, 16'h0000, 16'hffff, 16'h0000);
      send(16'hffff, 16'h0000, 16'hffff, 16'h0000, 16'h8000);
      send(16'h4000, 16'h0000, 16'h0000, 16'h1234, 16'h1234);
      send(16'h0000, 16'h4000, 16'h4000, 16'hedcc, 16'h1234);
      send(16'h5555, 16'haaaa, 16'h5555, 16'haaaa, 16'h5555);
      send(16'haaaa, 16'h5555, 16'haaaa, 16'h5555, 16'haaaa);
      send(16'h0100, 16'h0003, 16'hfffd, 16'h7fff, 16'h0001);
      drain();

      write_decl(16'sd18000);
      send(16'h0000, 16'h0000, 16'h0000, 16'h8000, 16'h0000);
      send(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
      random_phase(400);
      drain();

      write_decl(-16'sd18000);
      send(16'h0000, 16'h0000, 16'h0000, 16'h8000, 16'h0000);
      send(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
      hold_ask = 1'b1;
      calm = 1'b1;
      random_phase(200);
      calm = 1'b0;
      random_phase(200);
      drain();

      write_decl(16'sh7fff);
      random_phase(300);
      drain();

      write_decl(16'sh8000);
      random_phase(300);
      drain();

      write_decl(16'sd0);
      calm = 1'b1;
      random_phase(200);
      calm = 1'b0;
      drain();

      repeat (3) begin
         write_decl(16'($signed($urandom_range(0, 36000)) - 18000));
         random_phase(150);
         drain();
      end

      $display("covered %0d requests, %0d results checked, declination at reset,",
               requests_sent, board.matched);
      $display("both range ends, beyond range and random, with one long result stall");
      if (board.errors == 0 && board.pending.size() == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule
